// ===== rtl/crc32w_pkg.sv =====
// crc32w_pkg: shared types, constants and the word update function of the crc32 word engine
// used by crc32w_update and crc32_word_engine; no dependencies
package crc32w_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_TOP  = 32'h8000_0000;

    // running message state
    typedef struct packed {
        logic [31:0] crc;
        logic [23:0] word_bytes;
        logic [1:0]  byte_count;
    } crc32w_state_t;

    // one column per input bit: bits 31:0 of crc, then bits 31:0 of the word
    typedef logic [31:0] crc32w_cols_t [64];

    // contribution of each single input bit to the 32-step msb-first update
    function automatic crc32w_cols_t crc32w_build_cols();
        crc32w_cols_t cols;
        logic [31:0]  c;
        logic [31:0]  w;
        logic         fb;
        for (int k = 0; k < 64; k++)
        begin
            c = (k < 32) ? (32'd1 << k) : 32'd0;
            w = (k >= 32) ? (32'd1 << (k - 32)) : 32'd0;
            for (int i = 0; i < 32; i++)
            begin
                fb = c[31] ^ w[31 - i];
                c  = {c[30:0], 1'b0};
                if (fb)
                begin
                    c = c ^ CRC_POLY;
                end
            end
            cols[k] = c;
        end
        return cols;
    endfunction

    localparam crc32w_cols_t CRC_COLS = crc32w_build_cols();

    // whole word update as one xor network over independent input bits
    function automatic logic [31:0] crc32w_word(input logic [31:0] crc,
                                                input logic [31:0] word);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (crc[i])
            begin
                acc = acc ^ CRC_COLS[i];
            end
            if (word[i])
            begin
                acc = acc ^ CRC_COLS[32 + i];
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/crc32_word_engine.sv =====
// crc32_word_engine: top level of the byte-stream crc-32 engine
// depends on crc32w_pkg and crc32w_update
//
// Takes one message byte per transaction on the slave stream (tuser marks the first byte,
// tlast the last) and packs bytes little-endian into 32-bit words, each word going msb first
// into a crc-32 register (polynomial 0x04C11DB7, start value all ones, no reflection, no final
// xor); a partial final word is padded with zero high bytes. One crc transaction leaves on the
// master stream per last byte. The block takes one byte every cycle unless the slave side
// stalls: each byte is registered, then a single unrolled 32-bit xor network updates
// the state register and, for a last byte, the result register. The slave side
// stalls only when a last byte waits behind a result that the master side has not taken.
module crc32_word_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] crc_value
);
    import crc32w_pkg::*;

    logic          in_vld_reg;
    logic [7:0]    in_byte_reg;
    logic          in_first_reg;
    logic          in_last_reg;
    crc32w_state_t state_reg;
    crc32w_state_t state_next;
    logic          out_vld_reg;
    logic [31:0]   out_crc_reg;
    logic [31:0]   out_crc_next;
    logic          out_free;
    logic          advance;

    // the held byte moves on unless it is a last byte blocked by a waiting result
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign advance       = in_vld_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
    end

    // state update logic
    crc32w_update u_update (
        .cur        (state_reg),
        .data_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .nxt        (state_next),
        .crc_value  (out_crc_next)
    );

    // running crc state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.crc        <= CRC_INIT;
            state_reg.word_bytes <= '0;
            state_reg.byte_count <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_crc_reg <= out_crc_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_crc_reg;

endmodule

// ===== rtl/crc32w_update.sv =====
// crc32w_update: combinational next state for one message byte
// depends on crc32w_pkg
module crc32w_update (
    input  crc32w_pkg::crc32w_state_t cur,
    input  logic [7:0]                data_byte,
    input  logic                      first_byte,
    input  logic                      last_byte,
    output crc32w_pkg::crc32w_state_t nxt,
    output logic [31:0]               crc_value
);
    import crc32w_pkg::*;

    crc32w_state_t eff;
    logic [31:0]   word_ext;
    logic [31:0]   crc_upd;
    logic          word_full;

    // a first byte restarts the message
    always_comb
    begin
        if (first_byte)
        begin
            eff.crc        = CRC_INIT;
            eff.word_bytes = '0;
            eff.byte_count = '0;
        end
        else
        begin
            eff = cur;
        end
    end

    // place the byte little-endian, upper bytes stay zero as padding
    assign word_ext  = {8'd0, eff.word_bytes}
                     | ({24'd0, data_byte} << {eff.byte_count, 3'b000});
    assign word_full = (eff.byte_count == 2'd3);
    assign crc_upd   = crc32w_word(eff.crc, word_ext);
    assign crc_value = crc_upd;

    // a full word folds the word into the crc; the last byte restarts the state, its folded crc leaves on crc_value
    always_comb
    begin
        if (last_byte)
        begin
            nxt.crc        = CRC_INIT;
            nxt.word_bytes = '0;
            nxt.byte_count = '0;
        end
        else if (word_full)
        begin
            nxt.crc        = crc_upd;
            nxt.word_bytes = '0;
            nxt.byte_count = '0;
        end
        else
        begin
            nxt.crc        = eff.crc;
            nxt.word_bytes = word_ext[23:0];
            nxt.byte_count = eff.byte_count + 2'd1;
        end
    end

endmodule

// ===== rtl/crc32w_checker.sv =====
// crc32w_checker: port-level assertions for crc32_word_engine
// bound to the top level; no package dependencies
module crc32w_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("crc result changed while stalled");

    // a fresh result follows an accepted last byte, through the input and result registers
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("crc result without a last byte");

    // input only stalls behind a result that is not taken
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with free output");

endmodule

bind crc32_word_engine crc32w_checker u_crc32w_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for crc32_word_engine, byte stream in, crc-32 words out
// depends on crc32w_pkg for the crc constants and on the crc32_word_engine rtl
// bytes go in as directed messages then random ones, both sides idle at random
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crc32w_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 500;
    localparam int DRAIN_CYCLES = 6;

    // running crc of the message and the queue of crc words still owed
    class crc_scoreboard;
        logic [31:0] crc_run;
        logic [23:0] partial_word;
        logic [1:0]  held_bytes;
        logic [31:0] crc_owed_q[$];
        int          errors;

        function new();
            restart_message();
            errors = 0;
        endfunction

        function void restart_message();
            crc_run      = CRC_INIT;
            partial_word = '0;
            held_bytes   = '0;
        endfunction

        // shift one 32-bit word through the crc register, msb first
        function logic [31:0] fold_word(logic [31:0] crc, logic [31:0] word);
            logic fb;
            for (int i = 31; i >= 0; i--)
            begin
                fb  = crc[31] ^ word[i];
                crc = {crc[30:0], 1'b0};
                if (fb)
                begin
                    crc = crc ^ CRC_POLY;
                end
            end
            return crc;
        endfunction

        // accepted byte transaction: pack little-endian, emit crc on the last byte
        function void note_byte(logic [7:0] data, logic first, logic last);
            if (first)
            begin
                restart_message();
            end
            if (held_bytes == 2'd3)
            begin
                crc_run      = fold_word(crc_run, {data, partial_word});
                partial_word = '0;
                held_bytes   = '0;
            end
            else
            begin
                partial_word = partial_word | (24'(data) << (8 * held_bytes));
                held_bytes   = held_bytes + 2'd1;
            end
            if (last)
            begin
                // partial word padded with zero high bytes
                if (held_bytes != 2'd0)
                begin
                    crc_run = fold_word(crc_run, {8'h00, partial_word});
                end
                crc_owed_q.push_back(crc_run);
                restart_message();
            end
        endfunction

        // accepted crc transaction against the oldest owed value
        function void check_crc(logic [31:0] actual);
            logic [31:0] owed;
            if (crc_owed_q.size() == 0)
            begin
                $error("crc_value: expected none, actual %h", actual);
                errors++;
            end
            else
            begin
                owed = crc_owed_q.pop_front();
                if (actual !== owed)
                begin
                    $error("crc_value: expected %h, actual %h", owed, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return crc_owed_q.size();
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic        s_axis_tuser  = 1'b0; // [0] first_byte
    logic        s_axis_tlast  = 1'b0; // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] crc_value

    crc_scoreboard sb = new();
    bit            steady = 1'b0;  // when set neither side idles
    int            bytes_sent = 0;
    int            cycles = 0;

    crc32_word_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // monitor both streams
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_crc(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            end
        end
    end

    // result side: random stall before each crc transaction
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    // one byte transaction, after a random gap
    task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // reset, directed messages, random messages, drain
    initial
    begin
        int   len;
        int   start_count;
        bit   noisy;
        logic first;
        logic last;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte messages at both data extremes
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        // exactly one full word
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b1);
        // new message with no first flag, one byte into the second word
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b0);
        send_byte(8'h11, 1'b0, 1'b1);
        // restart in the middle of a partial word
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte(8'h56, 1'b1, 1'b0);
        send_byte(8'h78, 1'b0, 1'b0);
        send_byte(8'h9A, 1'b0, 1'b1);
        // first and last together after three held bytes
        send_byte(8'hC3, 1'b1, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b0);
        send_byte(8'hF0, 1'b1, 1'b1);
        // three-byte message, padded with one zero byte
        send_byte(8'hAA, 1'b1, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h81, 1'b0, 1'b1);

        // random messages, mostly well formed, some with stray flags
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            noisy = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                steady = ~steady;
            end
            for (int k = 0; k < len; k++)
            begin
                first = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 29) == 0);
                last  = (k == len - 1);
                if (noisy)
                begin
                    first = 1'($urandom_range(0, 1));
                    last  = 1'($urandom_range(0, 1));
                end
                send_byte(8'($urandom_range(0, 255)), first, last);
            end
        end
        s_axis_tvalid <= 1'b0;

        // wait for every owed crc, then drain for strays
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
